// ===== src/brp_pkg.sv =====
// brp_pkg: beat types, status codes and character constants of the byte range parser
// no dependencies; imported by every module of the block but brp_queue
`default_nettype none

package brp_pkg;

	// one header character beat
	typedef struct packed {
		logic [7:0]  header_char;
		logic        is_last;
		logic [63:0] resource_size;
	} hdr_t;

	// one resolved range beat
	typedef struct packed {
		logic [1:0]  range_status;
		logic [63:0] range_start;
		logic [63:0] range_end;
	} res_t;

	// syntax summary handed from the front to the back
	typedef struct packed {
		logic well_formed;
		logic start_seen;
		logic end_seen;
	} parse_flags_t;

	localparam logic [1:0] ST_IGNORE = 2'd0;
	localparam logic [1:0] ST_UNSAT  = 2'd1;
	localparam logic [1:0] ST_VALID  = 2'd2;

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [2:0] UNIT_LEN = 3'd6;

	// "bytes=" in lower case, one character per position
	function automatic logic [7:0] unit_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = 8'h62;
			3'd1: ch = 8'h79;
			3'd2: ch = 8'h74;
			3'd3: ch = 8'h65;
			3'd4: ch = 8'h73;
			3'd5: ch = 8'h3D;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== src/http_byte_range_parser.sv =====
// http_byte_range_parser: top level, a char per cycle in unless stalled, a range per header out
// depends on brp_pkg, brp_front, brp_queue, brp_back
// the last beat's summary is queued, then the back resolves it into the registered result
// throughput: one character beat per cycle unless the two-entry queue is full
// results drain at one per cycle while res_ready is high
// reset: arst_n low clears parser state, queue pointers and the result valid at once
`default_nettype none

module http_byte_range_parser import brp_pkg::*; #(
	parameter int OFFSET_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// character channel
	input  wire logic hdr_valid,
	output logic      hdr_ready,
	input  wire hdr_t hdr,
	// result channel
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	localparam int QW = $bits(parse_flags_t) + 3 * OFFSET_WIDTH;

	// front to queue
	logic                    push;
	parse_flags_t            push_flags;
	logic [OFFSET_WIDTH-1:0] push_start;
	logic [OFFSET_WIDTH-1:0] push_end;
	logic [OFFSET_WIDTH-1:0] push_size;

	// queue to back
	logic                    q_full;
	logic                    q_nonempty;
	logic                    q_pop;
	logic [QW-1:0]           q_head;
	parse_flags_t            q_flags;
	logic [OFFSET_WIDTH-1:0] q_start;
	logic [OFFSET_WIDTH-1:0] q_end;
	logic [OFFSET_WIDTH-1:0] q_size;

	logic hdr_fire;

	// every character is taken while the queue has room, so only a stalled
	// result channel with a full queue holds the character stream back
	assign hdr_ready = !q_full;
	assign hdr_fire  = hdr_valid && hdr_ready;

	// front: prefix match, space skipping and the two saturating accumulators
	brp_front #(
		.OW (OFFSET_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr        (hdr),
		.hdr_fire   (hdr_fire),
		.push       (push),
		.push_flags (push_flags),
		.push_start (push_start),
		.push_end   (push_end),
		.push_size  (push_size)
	);

	// decoupling queue: one summary per header value
	brp_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_start, push_end, push_size}),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	assign {q_flags, q_start, q_end, q_size} = q_head;

	// back: range resolution against the size, then the output register
	brp_back #(
		.OW (OFFSET_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_nonempty),
		.q_flags   (q_flags),
		.q_start   (q_start),
		.q_end     (q_end),
		.q_size    (q_size),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

// ===== src/brp_front.sv =====
// brp_front: per-character syntax tracker and saturating decimal accumulators
// depends on brp_pkg
`default_nettype none

module brp_front import brp_pkg::*; #(
	parameter int OW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hdr_t          hdr,
	input  wire logic          hdr_fire,
	output logic               push,
	output parse_flags_t       push_flags,
	output logic [OW-1:0]      push_start,
	output logic [OW-1:0]      push_end,
	output logic [OW-1:0]      push_size
);

	localparam logic [2:0] PH_PREFIX = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_START  = 3'd2;
	localparam logic [2:0] PH_END    = 3'd3;
	localparam logic [2:0] PH_TRAIL  = 3'd4;
	localparam logic [2:0] PH_BAD    = 3'd5;

	logic [2:0]    phase_q, phase_n;
	logic [2:0]    pos_q, pos_n;
	logic [OW-1:0] start_q, start_n;
	logic [OW-1:0] end_q, end_n;
	logic          ss_q, ss_n;
	logic          es_q, es_n;

	logic [7:0]    ch;
	logic [7:0]    low;
	logic          is_digit;
	logic [3:0]    dval;
	logic [OW-1:0] start_acc;
	logic [OW-1:0] end_acc;

	// acc*10 + d, clamped to all ones on overflow
	function automatic logic [OW-1:0] acc_digit(input logic [OW-1:0] acc, input logic [3:0] d);
		logic [OW+3:0] wide;
		wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{OW{1'b0}}, d};
		return (wide[OW+3:OW] != 4'd0) ? {OW{1'b1}} : wide[OW-1:0];
	endfunction

	assign ch       = hdr.header_char;
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign low      = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ? (ch + CASE_OFFSET) : ch;
	assign dval     = ch[3:0];
	assign start_acc = acc_digit(start_q, dval);
	assign end_acc   = acc_digit(end_q, dval);

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		start_n = start_q;
		end_n   = end_q;
		ss_n    = ss_q;
		es_n    = es_q;
		unique case (phase_q)
			PH_PREFIX: begin
				if (pos_q < UNIT_LEN && low == unit_char(pos_q)) begin
					pos_n = pos_q + 3'd1;
					if (pos_n == UNIT_LEN) begin
						phase_n = PH_LEAD;
					end
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_LEAD: begin
				if (ch == CH_SPACE) begin
					phase_n = PH_LEAD;
				end else if (is_digit) begin
					ss_n    = 1'b1;
					start_n = start_acc;
					phase_n = PH_START;
				end else if (ch == CH_DASH) begin
					phase_n = PH_END;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_START: begin
				if (is_digit) begin
					start_n = start_acc;
				end else if (ch == CH_DASH) begin
					phase_n = PH_END;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_END: begin
				if (is_digit) begin
					es_n  = 1'b1;
					end_n = end_acc;
				end else if (ch == CH_SPACE) begin
					phase_n = PH_TRAIL;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_TRAIL: begin
				if (ch != CH_SPACE) begin
					phase_n = PH_BAD;
				end
			end
			default: begin
				phase_n = PH_BAD;
			end
		endcase
	end

	// the last character closes the header: hand the summary on and start afresh
	assign push                   = hdr_fire && hdr.is_last;
	assign push_flags.well_formed = (phase_n == PH_END) || (phase_n == PH_TRAIL);
	assign push_flags.start_seen  = ss_n;
	assign push_flags.end_seen    = es_n;
	assign push_start             = start_n;
	assign push_end               = end_n;
	assign push_size              = hdr.resource_size[OW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= 3'd0;
			start_q <= '0;
			end_q   <= '0;
			ss_q    <= 1'b0;
			es_q    <= 1'b0;
		end else if (hdr_fire) begin
			if (hdr.is_last) begin
				phase_q <= PH_PREFIX;
				pos_q   <= 3'd0;
				start_q <= '0;
				end_q   <= '0;
				ss_q    <= 1'b0;
				es_q    <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				start_q <= start_n;
				end_q   <= end_n;
				ss_q    <= ss_n;
				es_q    <= es_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/brp_queue.sv =====
// brp_queue: two-entry queue of parse summaries between front and back
// no package dependencies
`default_nettype none

module brp_queue #(
	parameter int DATA_W = 195
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic                   full,
	output logic                   nonempty,
	output logic [DATA_W-1:0]      head
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/brp_back.sv =====
// brp_back: resolves a parse summary against the body size into a result beat
// depends on brp_pkg
`default_nettype none

module brp_back import brp_pkg::*; #(
	parameter int OW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire parse_flags_t  q_flags,
	input  wire logic [OW-1:0] q_start,
	input  wire logic [OW-1:0] q_end,
	input  wire logic [OW-1:0] q_size,
	output logic               pop,
	output logic               res_valid,
	input  wire logic          res_ready,
	output res_t               res
);

	logic          valid_q;
	res_t          res_q;
	logic [1:0]    status;
	logic [OW-1:0] rs;
	logic [OW-1:0] re;
	logic [OW-1:0] last_byte;
	logic [OW-1:0] suffix_start;
	logic          end_past;
	logic          start_past;

	assign last_byte    = q_size - {{(OW-1){1'b0}}, 1'b1};
	assign suffix_start = q_size - q_end;
	assign end_past     = (q_end >= q_size);
	assign start_past   = (q_start >= q_size);

	always_comb begin
		status = ST_IGNORE;
		rs     = q_start;
		re     = q_end;
		if (!q_flags.well_formed) begin
			status = ST_IGNORE;
		end else if (!q_flags.start_seen) begin
			if (!q_flags.end_seen || q_end == '0) begin
				status = ST_UNSAT;
			end else if (q_size == '0) begin
				status = ST_IGNORE;
			end else begin
				rs     = end_past ? '0 : suffix_start;
				re     = last_byte;
				status = ST_VALID;
			end
		end else if (start_past) begin
			status = ST_UNSAT;
		end else if (!q_flags.end_seen || end_past) begin
			re     = last_byte;
			status = ST_VALID;
		end else begin
			status = (q_start > q_end) ? ST_UNSAT : ST_VALID;
		end
		if (status != ST_VALID) begin
			rs = '0;
			re = '0;
		end
	end

	assign pop       = q_valid && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.range_status <= status;
			res_q.range_start  <= 64'(rs);
			res_q.range_end    <= 64'(re);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/brp_checker.sv =====
// brp_checker: port-level checks on the byte range parser, bound to the top level
// depends on brp_pkg and http_byte_range_parser
`default_nettype none

module brp_checker import brp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic hdr_valid,
	input wire logic hdr_ready,
	input wire hdr_t hdr,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire res_t res
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// a fresh result always traces back to an accepted last character
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(hdr_valid && hdr_ready && hdr.is_last, 2))
		else $error("result without a closing character");

	// a closing character into an idle output is followed by a result
	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_ready && hdr.is_last && !res_valid |=> ##1 res_valid)
		else $error("closing character produced no result");

	// satisfiable ranges are ordered, all other results carry zero offsets
	a_res_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.range_status == ST_VALID && res.range_start <= res.range_end)
			|| ((res.range_status == ST_IGNORE || res.range_status == ST_UNSAT)
			&& res.range_start == 64'd0 && res.range_end == 64'd0))
		else $error("malformed result beat");

endmodule

bind http_byte_range_parser brp_checker u_brp_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking bench for http_byte_range_parser, header characters in, resolved ranges out
// holds its own range predictor and drives both beat channels with random idling
// depends on brp_pkg and http_byte_range_parser
`default_nettype none

module tb;
	import brp_pkg::*;

	typedef enum logic [2:0] {
		SC_UNIT, SC_LEAD, SC_FIRST, SC_LAST, SC_TAIL, SC_JUNK
	} scan_phase_e;

	localparam logic [47:0] UNIT_TEXT = "bytes=";
	localparam logic [63:0] OFS_MAX   = '1;
	localparam logic [7:0]  CH_COMMA  = ",";
	localparam logic [7:0]  CH_NUL    = 8'h00;
	localparam logic [7:0]  CH_TOP    = 8'hFF;
	localparam logic [7:0]  CH_LOWER_A = CH_UPPER_A + CASE_OFFSET;
	localparam logic [7:0]  CH_LOWER_Z = CH_UPPER_Z + CASE_OFFSET;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hdr_valid = 1'b0;
	logic hdr_ready;
	hdr_t hdr = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	// predictor state: a copy of the parser registers
	scan_phase_e sc_phase;
	logic [2:0]  sc_pos;
	logic [63:0] first_acc, last_acc;
	logic        first_seen, last_seen;

	res_t        range_q[$];     // ranges still owed by the block, oldest first
	logic [7:0]  text_q[$];      // header value being sent
	int unsigned chars_sent;
	int unsigned mismatch_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_left;

	http_byte_range_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_scan();
		sc_phase   = SC_UNIT;
		sc_pos     = '0;
		first_acc  = '0;
		last_acc   = '0;
		first_seen = 1'b0;
		last_seen  = 1'b0;
	endfunction

	// decimal accumulate that sticks at all ones instead of wrapping
	function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] ch);
		logic [63:0] d;
		d = 64'(ch - CH_ZERO);
		if (acc > (OFS_MAX - d) / 10)
			return OFS_MAX;
		return acc * 10 + d;
	endfunction

	function automatic void scan_char(input logic [7:0] ch);
		logic       is_digit;
		logic [7:0] folded;
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		folded   = (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + CASE_OFFSET : ch;
		case (sc_phase)
			SC_UNIT: begin
				if (sc_pos < UNIT_LEN && folded == UNIT_TEXT[8*(5-int'(sc_pos)) +: 8]) begin
					sc_pos = sc_pos + 3'd1;
					if (sc_pos == UNIT_LEN)
						sc_phase = SC_LEAD;
				end else begin
					sc_phase = SC_JUNK;
				end
			end
			SC_LEAD: begin
				if (ch == CH_SPACE) begin
				end else if (is_digit) begin
					first_seen = 1'b1;
					first_acc  = add_digit(first_acc, ch);
					sc_phase   = SC_FIRST;
				end else if (ch == CH_DASH) begin
					sc_phase = SC_LAST;
				end else begin
					sc_phase = SC_JUNK;
				end
			end
			SC_FIRST: begin
				if (is_digit)
					first_acc = add_digit(first_acc, ch);
				else if (ch == CH_DASH)
					sc_phase = SC_LAST;
				else
					sc_phase = SC_JUNK;
			end
			SC_LAST: begin
				if (is_digit) begin
					last_seen = 1'b1;
					last_acc  = add_digit(last_acc, ch);
				end else if (ch == CH_SPACE) begin
					sc_phase = SC_TAIL;
				end else begin
					sc_phase = SC_JUNK;
				end
			end
			SC_TAIL: begin
				if (ch != CH_SPACE)
					sc_phase = SC_JUNK;
			end
			default: sc_phase = SC_JUNK;
		endcase
	endfunction

	// resolve the parsed numbers against the body size, then start afresh
	function automatic res_t resolve_range(input logic [63:0] size);
		res_t        r;
		logic [63:0] s, e;
		r = '0;
		r.range_status = ST_IGNORE;
		s = first_acc;
		e = last_acc;
		if (sc_phase == SC_LAST || sc_phase == SC_TAIL) begin
			if (!first_seen) begin
				if (!last_seen || e == 0) begin
					r.range_status = ST_UNSAT;
				end else if (size == 0) begin
					r.range_status = ST_IGNORE;
				end else begin
					// suffix: the last e bytes, no more than the whole body
					s = (e >= size) ? 64'd0 : size - e;
					e = size - 1;
					r.range_status = ST_VALID;
				end
			end else if (s >= size) begin
				r.range_status = ST_UNSAT;
			end else begin
				if (!last_seen || e >= size)
					e = size - 1;
				r.range_status = (s > e) ? ST_UNSAT : ST_VALID;
			end
		end
		if (r.range_status == ST_VALID) begin
			r.range_start = s;
			r.range_end   = e;
		end
		clear_scan();
		return r;
	endfunction

	// ---------------------------------------------------------------- beat drivers

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// entered and left just after a falling edge
	task automatic send_char(input logic [7:0] ch, input logic last, input logic [63:0] size);
		while ($urandom_range(99) < send_idle_pct) begin
			hdr_valid <= 1'b0;
			hdr       <= hdr_t'({9'($urandom), rand_word()});
			@(negedge clk);
		end
		hdr_valid <= 1'b1;
		hdr       <= '{header_char: ch, is_last: last, resource_size: size};
		do @(posedge clk); while (!hdr_ready);
		scan_char(ch);
		if (last)
			range_q.push_back(resolve_range(size));
		chars_sent++;
		@(negedge clk);
	endtask

	// size only matters on the last beat, earlier beats carry noise there
	task automatic send_text(input logic [63:0] size);
		for (int i = 0; i < text_q.size(); i++) begin
			if (i == text_q.size() - 1)
				send_char(text_q[i], 1'b1, size);
			else
				send_char(text_q[i], 1'b0, rand_word());
		end
	endtask

	task automatic send_str(input string s, input logic [63:0] size);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text(size);
	endtask

	// receiver: random stalls plus a long hold-off set by the backpressure test
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- result check

	function automatic void flag_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (mismatch_count < 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		mismatch_count++;
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (range_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("result beat with nothing owed: status %0d start %0d end %0d",
						res.range_status, res.range_start, res.range_end);
				mismatch_count++;
			end else begin
				want = range_q.pop_front();
				if (res.range_status !== want.range_status)
					flag_field("range_status", 64'(want.range_status), 64'(res.range_status));
				if (res.range_start !== want.range_start)
					flag_field("range_start", want.range_start, res.range_start);
				if (res.range_end !== want.range_end)
					flag_field("range_end", want.range_end, res.range_end);
			end
		end
	end

	// ---------------------------------------------------------------- random headers

	task automatic push_digits();
		int n;
		n = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 5);
		repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic push_spaces();
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) text_q.push_back(CH_SPACE);
	endtask

	task automatic send_random_header();
		int          kind;
		int          pos;
		logic [7:0]  ch;
		logic [63:0] size;
		text_q.delete();
		kind = $urandom_range(99);
		if (kind < 10) begin
			// plain noise, mostly dies in the unit prefix
			repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(255)));
		end else begin
			for (int i = 0; i < 6; i++) begin
				ch = UNIT_TEXT[8*(5-i) +: 8];
				if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z && $urandom_range(1))
					ch = ch - CASE_OFFSET;
				text_q.push_back(ch);
			end
			push_spaces();
			if ($urandom_range(3) != 0)
				push_digits();
			text_q.push_back(CH_DASH);
			if ($urandom_range(3) != 0)
				push_digits();
			push_spaces();
			if (kind < 28) begin
				// broken sequence: cut short, corrupt a byte, or slip in a comma or space
				pos = $urandom_range(text_q.size() - 1);
				case ($urandom_range(2))
					0: while (text_q.size() > pos + 1) void'(text_q.pop_back());
					1: text_q[pos] = 8'($urandom_range(255));
					default: text_q.insert(pos, $urandom_range(1) ? CH_COMMA : CH_SPACE);
				endcase
			end
		end
		case ($urandom_range(9))
			0: size = '0;
			1: size = OFS_MAX;
			2: size = rand_word();
			3: size = 64'($urandom_range(1, 10));
			default: size = 64'($urandom_range(0, 20000));
		endcase
		send_text(size);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_resolution();
		send_str("bytes=0-499", 64'd1000);
		send_str("BYTES=  500-", 64'd1000);
		send_str("bytes=-200", 64'd1000);
		send_str("bYtEs=-5000", 64'd100);
		send_str("bytes=-0", 64'd10);
		send_str("bytes=-", 64'd10);
		send_str("bytes=-5", 64'd0);
		send_str("bytes=100-", 64'd100);
		send_str("bytes=50-20", 64'd100);
		send_str("bytes=0-999999", 64'd10);
		send_str("bytes=0-0", 64'd1);
		send_str("bytes=1-2  ", 64'd10);
	endtask

	task automatic test_malformed();
		send_str("bytes=0-1,2-3", 64'd100);
		send_str("bytes=5 -9", 64'd100);
		send_str("bytes=5", 64'd100);
		send_str("byt", 64'd100);
		send_str("bites=0-1", 64'd100);
		send_str("bytes=1-2 x", 64'd100);
		send_str("bytes=", 64'd100);
		send_str("bytes=-1-", 64'd100);
		// a zero byte after the dash, then the top character code
		text_q = '{"b", "y", "t", "e", "s", "=", "1", CH_DASH, CH_NUL};
		send_text(64'd100);
		text_q = '{"b", "y", "t", "e", "s", "=", CH_TOP};
		send_text(64'd100);
	endtask

	task automatic test_extremes();
		// numbers past 64 bits stick at all ones
		send_str("bytes=99999999999999999999999-", OFS_MAX);
		send_str("bytes=18446744073709551614-", OFS_MAX);
		send_str("bytes=-99999999999999999999999", OFS_MAX);
		send_str("bytes=0-", OFS_MAX);
	endtask

	task automatic test_backpressure();
		// sender pauses until the block has nothing left to give
		hdr_valid <= 1'b0;
		do @(negedge clk); while (range_q.size() != 0);
		// receiver holds off while short headers pile up behind the full queue
		hold_left = 60;
		repeat (6) begin
			send_str("-", rand_word());
			send_str("bytes=0-3", 64'd8);
		end
	endtask

	task automatic test_random_headers(input int unsigned char_budget);
		int unsigned first;
		first = chars_sent;
		while (chars_sent - first < char_budget)
			send_random_header();
	endtask

	// ---------------------------------------------------------------- run

	initial begin
		chars_sent     = 0;
		mismatch_count = 0;
		hold_left      = 0;
		send_idle_pct  = 28;
		recv_idle_pct  = 57;
		clear_scan();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_resolution();
		test_malformed();
		test_extremes();
		test_random_headers(340);
		test_backpressure();

		send_idle_pct = 57;
		recv_idle_pct = 28;
		test_random_headers(340);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_headers(340);

		hdr_valid <= 1'b0;
		while (range_q.size() != 0) @(posedge clk);
		// a stray late beat would show up during this wait
		repeat (6) @(posedge clk);
		if (mismatch_count + range_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/brp_pkg.sv
src/brp_front.sv
src/brp_queue.sv
src/brp_back.sv
src/http_byte_range_parser.sv
src/brp_checker.sv
verif/tb.sv
